[sv/lease_reservation_table_macros.svh]
// Assertion macros shared by the lease reservation table RTL.
`ifndef LEASE_RESERVATION_TABLE_MACROS_SVH
`define LEASE_RESERVATION_TABLE_MACROS_SVH
`ifndef SYNTH
`define LRT_ASSERT_IMP(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
`define LRT_ASSERT_NXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`else
`define LRT_ASSERT_IMP(label, clk, rst_n, pre, post)
`define LRT_ASSERT_NXT(label, clk, rst_n, pre, post)
`endif
`endif

[sv/lrt_pkg.sv]
`default_nettype none
package lrt_pkg;
    localparam int NUM_MARKERS = 20;
    localparam int IDX_W = $clog2(NUM_MARKERS);

    localparam logic [1:0] CMD_RESERVE = 2'd0;
    localparam logic [1:0] CMD_LAND    = 2'd1;
    localparam logic [1:0] CMD_TICK    = 2'd2;
    localparam logic [1:0] CMD_REPORT  = 2'd3;

    localparam logic [1:0] ST_FREE     = 2'd0;
    localparam logic [1:0] ST_RESERVED = 2'd1;
    localparam logic [1:0] ST_LANDED   = 2'd2;

    localparam logic [1:0] KIND_REPLY = 2'd0;
    localparam logic [1:0] KIND_LIST  = 2'd1;
    localparam logic [1:0] KIND_EMPTY = 2'd2;

    localparam logic [2:0] STS_RESERVED  = 3'd0;
    localparam logic [2:0] STS_RENEWED   = 3'd1;
    localparam logic [2:0] STS_LANDED    = 3'd2;
    localparam logic [2:0] STS_UNKNOWN   = 3'd3;
    localparam logic [2:0] STS_NOT_RES   = 3'd4;
    localparam logic [2:0] STS_OTHER     = 3'd5;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] marker_number;
        logic [7:0] drone_number;
    } t_in_item;

    typedef struct packed {
        logic [1:0] kind;
        logic       success;
        logic [2:0] status;
        logic [7:0] out_marker;
        logic [7:0] owner_drone;
        logic       last;
    } t_out_item;

    typedef struct packed {
        logic [1:0]  st;
        logic [7:0]  owner;
        logic [31:0] stamp;
    } t_entry;
endpackage
`default_nettype wire

[sv/lrt_if.sv]
`default_nettype none
interface lrt_in_if;
    logic              valid;
    logic              ready;
    lrt_pkg::t_in_item payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface lrt_out_if;
    logic               valid;
    logic               ready;
    lrt_pkg::t_out_item payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

[sv/lease_reservation_table.sv]
// Lease reservation table.
// Input items arrive on i_in (valid/ready); a transfer happens at a clock edge
// where both are high. Results leave on o_out with the same handshake; the
// final result caused by an input has last set. The cooldown register is
// written through i_cfg_we/i_cfg_data; the user writes it only while the
// block is idle, which the block itself does not enforce. All entries live
// in one synchronous memory whose read data is registered. A tick is taken
// in the accepting cycle and the block is ready again in the next one. A
// reserve or a report first walks all entries with a read-modify-write sweep
// (a read and a check state per entry, for expiry when needed), then a
// reserve looks up the requested entry. A land looks up its entry directly
// and, when it succeeds, runs the same expiry sweep after its reply. A grant,
// a successful land and a report then sweep again to list non-free ids (a
// read and a check state per entry, plus an output state per listed one,
// ending at the last listed entry). One item is handled at a time. After
// reset the block clears the memory, one entry a cycle, and accepts no item
// meanwhile. A stalled receiver holds the output register and the sweep
// waits; no result is lost.
`default_nettype none
`include "lease_reservation_table_macros.svh"
module lease_reservation_table (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_cfg_we,
    input  wire logic [31:0] i_cfg_data,
    lrt_in_if.sink      i_in,
    lrt_out_if.source   o_out
);
    import lrt_pkg::*;

    localparam logic [3:0] S_CLR    = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_XRD    = 4'd2;  // expiry sweep read
    localparam logic [3:0] S_XWR    = 4'd3;  // expiry sweep check/write
    localparam logic [3:0] S_LRD    = 4'd4;  // lookup read
    localparam logic [3:0] S_LDEC   = 4'd5;  // lookup decide
    localparam logic [3:0] S_RPLY   = 4'd6;  // reply waiting for transfer
    localparam logic [3:0] S_SRD    = 4'd7;  // list sweep read
    localparam logic [3:0] S_SCHK   = 4'd8;  // list sweep check
    localparam logic [3:0] S_SOUT   = 4'd9;  // list item waiting
    localparam logic [3:0] S_EMPTY  = 4'd10;

    t_entry mem [NUM_MARKERS];
    t_entry rd_data;
    logic   we;
    logic [IDX_W-1:0] waddr, raddr;
    t_entry wdata;

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rd_data <= mem[raddr];
    end

    logic [3:0]       r_state;
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] r_lastnf;
    logic [31:0]      r_cool, r_time;
    t_in_item         r_cmd;
    logic             r_any, r_list;
    t_out_item        r_out;
    logic             r_ov;

    logic known;
    logic [IDX_W-1:0] req_idx;
    logic [31:0] age;
    logic last_idx;
    logic stale;

    assign known = (r_cmd.marker_number >= 8'd1) &&
                   (r_cmd.marker_number <= 8'(NUM_MARKERS));
    assign req_idx = IDX_W'(r_cmd.marker_number - 8'd1);
    assign age = r_time - rd_data.stamp;
    assign last_idx = (r_idx == IDX_W'(NUM_MARKERS - 1));
    assign stale = (rd_data.st == ST_RESERVED) && (age > r_cool);

    assign i_in.ready = (r_state == S_IDLE);
    assign o_out.valid = r_ov;
    assign o_out.payload = r_out;

    // Memory port control for the current state.
    always_comb begin
        we = 1'b0;
        waddr = r_idx;
        raddr = r_idx;
        wdata = rd_data;
        case (r_state)
            S_CLR: begin
                we = 1'b1;
                wdata = '0;
            end
            S_XWR: begin
                if (stale) begin
                    we = 1'b1;
                    wdata.st = ST_FREE;
                    wdata.owner = '0;
                    wdata.stamp = r_time;
                end
            end
            S_LRD: raddr = req_idx;
            S_LDEC: begin
                waddr = req_idx;
                if (known) begin
                    if (r_cmd.command == CMD_RESERVE) begin
                        if (rd_data.st == ST_FREE) begin
                            we = 1'b1;
                            wdata.st = ST_RESERVED;
                            wdata.owner = r_cmd.drone_number;
                            wdata.stamp = r_time;
                        end else if (rd_data.owner == r_cmd.drone_number) begin
                            we = 1'b1;
                            wdata.stamp = r_time;
                        end
                    end else if (rd_data.st != ST_FREE &&
                                 rd_data.owner == r_cmd.drone_number) begin
                        we = 1'b1;
                        wdata.st = ST_LANDED;
                        wdata.stamp = r_time;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_idx <= '0;
            r_lastnf <= '0;
            r_cool <= 32'd30;
            r_time <= '0;
            r_ov <= 1'b0;
            r_any <= 1'b0;
            r_list <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cool <= i_cfg_data;
            end
            if (r_ov && o_out.ready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_CLR: begin
                    r_idx <= r_idx + 1'b1;
                    if (last_idx) begin
                        r_state <= S_IDLE;
                        r_idx <= '0;
                    end
                end
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_cmd <= i_in.payload;
                        r_idx <= '0;
                        r_lastnf <= '0;
                        r_any <= 1'b0;
                        case (i_in.payload.command)
                            CMD_TICK:   r_time <= r_time + 32'd1;
                            CMD_LAND:   r_state <= S_LRD;
                            default:    r_state <= S_XRD;
                        endcase
                    end
                end
                S_XRD: r_state <= S_XWR;
                S_XWR: begin
                    // Track the highest entry that stays non-free, so the list
                    // can flag its final item.
                    if (rd_data.st != ST_FREE && !stale) begin
                        r_lastnf <= r_idx;
                    end
                    r_idx <= r_idx + 1'b1;
                    r_state <= S_XRD;
                    if (last_idx) begin
                        r_idx <= '0;
                        r_state <= (r_cmd.command == CMD_REPORT) ? S_SRD : S_LRD;
                    end
                end
                S_LRD: r_state <= S_LDEC;
                S_LDEC: begin
                    r_out.kind <= KIND_REPLY;
                    r_out.out_marker <= r_cmd.marker_number;
                    r_out.owner_drone <= '0;
                    r_out.success <= 1'b0;
                    r_out.last <= 1'b1;
                    r_list <= 1'b0;
                    if (!known) begin
                        r_out.status <= STS_UNKNOWN;
                    end else if (r_cmd.command == CMD_RESERVE) begin
                        if (rd_data.st == ST_FREE) begin
                            r_out.status <= STS_RESERVED;
                            r_out.success <= 1'b1;
                            r_out.last <= 1'b0;
                            r_list <= 1'b1;
                            if (req_idx > r_lastnf) begin
                                r_lastnf <= req_idx;
                            end
                        end else if (rd_data.owner == r_cmd.drone_number) begin
                            r_out.status <= STS_RENEWED;
                            r_out.success <= 1'b1;
                        end else begin
                            r_out.status <= STS_OTHER;
                            r_out.owner_drone <= rd_data.owner;
                        end
                    end else if (rd_data.st == ST_FREE) begin
                        r_out.status <= STS_NOT_RES;
                    end else if (rd_data.owner != r_cmd.drone_number) begin
                        r_out.status <= STS_OTHER;
                        r_out.owner_drone <= rd_data.owner;
                    end else begin
                        r_out.status <= STS_LANDED;
                        r_out.success <= 1'b1;
                        r_out.last <= 1'b0;
                        r_list <= 1'b1;
                    end
                    r_ov <= 1'b1;
                    r_state <= S_RPLY;
                end
                S_RPLY: begin
                    if (o_out.ready) begin
                        r_idx <= '0;
                        // After a successful land, the expiry sweep runs before the list.
                        if (!r_list) begin
                            r_state <= S_IDLE;
                        end else if (r_cmd.command == CMD_LAND) begin
                            r_cmd.command <= CMD_REPORT;
                            r_state <= S_XRD;
                        end else begin
                            r_state <= S_SRD;
                        end
                    end
                end
                S_SRD: r_state <= S_SCHK;
                S_SCHK: begin
                    if (rd_data.st != ST_FREE) begin
                        r_out.kind <= KIND_LIST;
                        r_out.success <= 1'b0;
                        r_out.status <= STS_RESERVED;
                        r_out.out_marker <= 8'(r_idx) + 8'd1;
                        r_out.owner_drone <= '0;
                        r_out.last <= (r_idx == r_lastnf);
                        r_ov <= 1'b1;
                        r_any <= 1'b1;
                        r_state <= S_SOUT;
                    end else if (last_idx) begin
                        r_state <= r_any ? S_IDLE : S_EMPTY;
                        if (!r_any) begin
                            r_out.kind <= KIND_EMPTY;
                            r_out.success <= 1'b0;
                            r_out.status <= STS_RESERVED;
                            r_out.out_marker <= '0;
                            r_out.owner_drone <= '0;
                            r_out.last <= 1'b1;
                            r_ov <= 1'b1;
                        end
                    end else begin
                        r_idx <= r_idx + 1'b1;
                        r_state <= S_SRD;
                    end
                end
                S_SOUT: begin
                    if (o_out.ready) begin
                        r_idx <= r_idx + 1'b1;
                        r_state <= r_out.last ? S_IDLE : S_SRD;
                    end
                end
                S_EMPTY: begin
                    if (o_out.ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // No item is accepted while the memory is being cleared after reset.
    // A held result never changes while stalled; while idle nothing is pending.
    `LRT_ASSERT_IMP(a_idle_no_out, i_clk, i_rst_n, r_state == S_IDLE, !r_ov)
    `LRT_ASSERT_NXT(a_hold, i_clk, i_rst_n, r_ov && !o_out.ready, $stable(r_out))
    `LRT_ASSERT_IMP(a_no_accept_busy, i_clk, i_rst_n, r_state == S_CLR, !i_in.ready)
endmodule
`default_nettype wire

[test/tb_lease_reservation_table.sv]
module tb_lease_reservation_table;
    import lrt_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 200;

    // Scoreboard that tracks the lease table and queues the result items that
    // each accepted command should produce on the output channel.
    class lease_scoreboard;
        logic [1:0]  ent_state [NUM_MARKERS];
        logic [7:0]  ent_owner [NUM_MARKERS];
        logic [31:0] ent_stamp [NUM_MARKERS];
        logic [31:0] now_ticks;
        logic [31:0] cooldown;
        t_out_item   pending_results[$];
        int          fail_count;

        function void clear();
            for (int i = 0; i < NUM_MARKERS; i++) begin
                ent_state[i] = ST_FREE;
                ent_owner[i] = 8'd0;
                ent_stamp[i] = 32'd0;
            end
            now_ticks = 32'd0;
            cooldown = 32'd30;
            pending_results.delete();
            fail_count = 0;
        endfunction

        // Any reserved entry older than the cooldown goes back to free.
        function void release_stale();
            for (int i = 0; i < NUM_MARKERS; i++) begin
                if (ent_state[i] == ST_RESERVED && (now_ticks - ent_stamp[i]) > cooldown) begin
                    ent_state[i] = ST_FREE;
                    ent_owner[i] = 8'd0;
                    ent_stamp[i] = now_ticks;
                end
            end
        endfunction

        function void push_result(logic [1:0] kind, logic ok, logic [2:0] sts,
                                  logic [7:0] id, logic [7:0] owner);
            t_out_item r;
            r.kind = kind;
            r.success = ok;
            r.status = sts;
            r.out_marker = id;
            r.owner_drone = owner;
            r.last = 1'b0;
            pending_results = {pending_results, r};
        endfunction

        function void push_busy_list();
            int n;
            n = 0;
            release_stale();
            for (int i = 0; i < NUM_MARKERS; i++) begin
                if (ent_state[i] != ST_FREE) begin
                    push_result(KIND_LIST, 1'b0, STS_RESERVED, 8'(i + 1), 8'd0);
                    n++;
                end
            end
            if (n == 0) push_result(KIND_EMPTY, 1'b0, STS_RESERVED, 8'd0, 8'd0);
        endfunction

        function void note_command(t_in_item it);
            int  before_n;
            int  idx;
            bit  known;
            before_n = pending_results.size();
            known = it.marker_number >= 1 && it.marker_number <= NUM_MARKERS;
            idx = known ? int'(it.marker_number) - 1 : 0;
            case (it.command)
                CMD_TICK: begin
                    now_ticks = now_ticks + 32'd1;
                end
                CMD_REPORT: begin
                    push_busy_list();
                end
                CMD_RESERVE: begin
                    release_stale();
                    if (!known) begin
                        push_result(KIND_REPLY, 1'b0, STS_UNKNOWN, it.marker_number, 8'd0);
                    end else if (ent_state[idx] == ST_FREE) begin
                        ent_state[idx] = ST_RESERVED;
                        ent_owner[idx] = it.drone_number;
                        ent_stamp[idx] = now_ticks;
                        push_result(KIND_REPLY, 1'b1, STS_RESERVED, it.marker_number, 8'd0);
                        push_busy_list();
                    end else if (ent_owner[idx] == it.drone_number) begin
                        ent_stamp[idx] = now_ticks;
                        push_result(KIND_REPLY, 1'b1, STS_RENEWED, it.marker_number, 8'd0);
                    end else begin
                        push_result(KIND_REPLY, 1'b0, STS_OTHER, it.marker_number,
                                    ent_owner[idx]);
                    end
                end
                default: begin
                    // Landing does not expire anything before the lookup.
                    if (!known) begin
                        push_result(KIND_REPLY, 1'b0, STS_UNKNOWN, it.marker_number, 8'd0);
                    end else if (ent_state[idx] == ST_FREE) begin
                        push_result(KIND_REPLY, 1'b0, STS_NOT_RES, it.marker_number, 8'd0);
                    end else if (ent_owner[idx] != it.drone_number) begin
                        push_result(KIND_REPLY, 1'b0, STS_OTHER, it.marker_number,
                                    ent_owner[idx]);
                    end else begin
                        ent_state[idx] = ST_LANDED;
                        ent_stamp[idx] = now_ticks;
                        push_result(KIND_REPLY, 1'b1, STS_LANDED, it.marker_number, 8'd0);
                        push_busy_list();
                    end
                end
            endcase
            if (pending_results.size() > before_n)
                pending_results[pending_results.size() - 1].last = 1'b1;
        endfunction

        function void check_result(t_out_item got);
            t_out_item exp_r;
            if (pending_results.size() == 0) begin
                $error("unexpected result transfer: %p", got);
                fail_count++;
                return;
            end
            exp_r = pending_results.pop_front();
            if (got.kind !== exp_r.kind) begin
                $error("kind: expected %0d actual %0d", exp_r.kind, got.kind);
                fail_count++;
            end
            if (got.success !== exp_r.success) begin
                $error("success: expected %0d actual %0d", exp_r.success, got.success);
                fail_count++;
            end
            if (got.status !== exp_r.status) begin
                $error("status: expected %0d actual %0d", exp_r.status, got.status);
                fail_count++;
            end
            if (got.out_marker !== exp_r.out_marker) begin
                $error("out_marker: expected %0d actual %0d", exp_r.out_marker,
                       got.out_marker);
                fail_count++;
            end
            if (got.owner_drone !== exp_r.owner_drone) begin
                $error("owner_drone: expected %0d actual %0d", exp_r.owner_drone,
                       got.owner_drone);
                fail_count++;
            end
            if (got.last !== exp_r.last) begin
                $error("last: expected %0d actual %0d", exp_r.last, got.last);
                fail_count++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [31:0] i_cfg_data;

    lrt_in_if  cmd_ch ();
    lrt_out_if res_ch ();

    lease_reservation_table DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in       (cmd_ch.sink),
        .o_out      (res_ch.source)
    );

    lease_scoreboard lease_sb;

    // Idle probabilities, in percent, for the sender and the receiver.
    int send_idle_pct;
    int recv_stall_pct;
    int idle_cycles;

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    initial begin
        lease_sb = new();
        lease_sb.clear();
    end

    // The receiver sets a random ready at the falling edge and checks every result
    // transfer at the rising edge.
    initial res_ch.ready = 1'b0;
    always @(negedge i_clk) begin
        res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready) lease_sb.check_result(res_ch.payload);
    end

    // The watchdog counts cycles without any transfer on either channel.
    always @(posedge i_clk) begin
        if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("** lease_reservation_table: FAILED **");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Presents one command and holds it until the block accepts the transfer.
    // Valid stays high across back-to-back items; it only drops for a gap.
    task automatic send_command(logic [1:0] cmd, logic [7:0] marker, logic [7:0] drone);
        t_in_item it;
        it.command = cmd;
        it.marker_number = marker;
        it.drone_number = drone;
        while ($urandom_range(99) < send_idle_pct) begin
            cmd_ch.valid <= 1'b0;
            cmd_ch.payload <= 18'($urandom);
            @(negedge i_clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.payload <= it;
        @(posedge i_clk);
        while (!cmd_ch.ready) @(posedge i_clk);
        lease_sb.note_command(it);
        @(negedge i_clk);
    endtask

    // Lets every expected result drain, then gives the block time to settle.
    task automatic wait_drained();
        cmd_ch.valid <= 1'b0;
        while (lease_sb.pending_results.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // Writes the cooldown register while the block is idle.
    task automatic write_cooldown(logic [31:0] value);
        wait_drained();
        i_cfg_we <= 1'b1;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        lease_sb.cooldown = value;
    endtask

    // Random traffic that favors valid ids and a small pool of drones so that
    // grants, renewals, refusals, landings and expiry all happen often.
    task automatic random_commands(int count);
        logic [1:0] cmd;
        logic [7:0] marker;
        logic [7:0] drone;
        for (int n = 0; n < count; n++) begin
            cmd = 2'($urandom_range(3));
            if ($urandom_range(99) < 85) marker = 8'($urandom_range(NUM_MARKERS, 1));
            else marker = 8'($urandom);
            if ($urandom_range(99) < 80) drone = 8'($urandom_range(3) * 85);
            else drone = 8'($urandom);
            send_command(cmd, marker, drone);
        end
    endtask

    initial begin
        idle_cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_data = 32'd0;
        cmd_ch.valid = 1'b0;
        cmd_ch.payload = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part with the reset cooldown of 30 ticks.
        send_command(CMD_REPORT, 8'd0, 8'd0);
        send_command(CMD_RESERVE, 8'd0, 8'd7);
        send_command(CMD_RESERVE, 8'd255, 8'd7);
        send_command(CMD_RESERVE, 8'd21, 8'd7);
        send_command(CMD_LAND, 8'd0, 8'd7);
        send_command(CMD_LAND, 8'd1, 8'd7);
        send_command(CMD_RESERVE, 8'd1, 8'd255);
        send_command(CMD_RESERVE, 8'd20, 8'd0);
        send_command(CMD_RESERVE, 8'd1, 8'd255);
        send_command(CMD_RESERVE, 8'd1, 8'd170);
        send_command(CMD_LAND, 8'd20, 8'd1);
        send_command(CMD_LAND, 8'd20, 8'd0);
        send_command(CMD_RESERVE, 8'd20, 8'd0);
        send_command(CMD_LAND, 8'd20, 8'd0);
        send_command(CMD_REPORT, 8'd255, 8'd255);
        for (int t = 0; t < 31; t++) send_command(CMD_TICK, 8'($urandom), 8'($urandom));
        send_command(CMD_REPORT, 8'd0, 8'd0);
        send_command(CMD_TICK, 8'd0, 8'd0);
        send_command(CMD_RESERVE, 8'd5, 8'd85);
        send_command(CMD_REPORT, 8'd0, 8'd0);

        // With a zero cooldown one tick is enough to free a reservation.
        write_cooldown(32'd0);
        send_command(CMD_TICK, 8'd0, 8'd0);
        send_command(CMD_RESERVE, 8'd3, 8'd9);
        send_command(CMD_REPORT, 8'd0, 8'd0);

        // Random phases with different idling patterns and cooldown settings.
        write_cooldown(32'd2);
        random_commands(40);

        write_cooldown(32'hFFFF_FFFF);
        send_idle_pct = 71;
        random_commands(40);

        write_cooldown(32'd5);
        send_idle_pct = 0;
        recv_stall_pct = 71;
        random_commands(40);

        write_cooldown(32'd1);
        send_idle_pct = 32;
        recv_stall_pct = 32;
        random_commands(40);

        send_idle_pct = 0;
        recv_stall_pct = 0;
        wait_drained();
        if (lease_sb.fail_count == 0 && lease_sb.pending_results.size() == 0) begin
            $display("** lease_reservation_table: PASSED **");
        end else begin
            $display("** lease_reservation_table: FAILED **");
        end
        $finish;
    end
endmodule
